// ----- hw/rtl/curve_follower_step_assert.svh -----
// Assertion macros for the curve follower step
`ifndef CURVE_FOLLOWER_STEP_ASSERT_SVH
`define CURVE_FOLLOWER_STEP_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define CFS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define CFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cfs_pkg.sv -----
package cfs_pkg;

  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned RegBits      = 48;
  localparam int unsigned TBits        = 16;
  localparam int unsigned TStep        = 655;
  localparam int unsigned NumRegs      = 4;
  localparam int unsigned CfgIdxBits   = 2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIX,
    ST_DIFF,
    ST_SQRT,
    ST_DIV,
    ST_UPD,
    ST_POS,
    ST_OUT
  } cfs_state_e;

  // Commands from sequencer to the mix unit
  typedef struct packed {
    logic       start;
    logic [1:0] axis;
    logic [1:0] sample;
  } cfs_mix_cmd_t;

endpackage

// ----- hw/rtl/cfs_mix.sv -----
// Shared mix unit: evaluates one coordinate of the curve in three steps,
// one multiply per cycle: l1 = mix(p1,p2,t), l2 = mix(p3,p4,t), mix(l1,l2,t).
module cfs_mix
  import cfs_pkg::*;
#(
  parameter int unsigned CoordBits = CoordBitsDef,
  parameter int unsigned WideBits  = CoordBits + 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [CoordBits-1:0] a_i,
  input  logic signed [CoordBits-1:0] b_i,
  input  logic signed [CoordBits-1:0] c_i,
  input  logic signed [CoordBits-1:0] d_i,
  input  logic [TBits:0]              t_i,
  output logic                        done_o,
  output logic signed [WideBits-1:0]  res_o
);

  localparam int unsigned ProdBits = WideBits + TBits + 3;

  logic [1:0] step_q, step_d;
  logic signed [WideBits-1:0] l1_q, l1_d, l2_q, l2_d;
  logic signed [WideBits-1:0] ma, mb;
  logic signed [ProdBits-1:0] prod;
  logic signed [WideBits-1:0] mixed;

  // operand selection per step
  always_comb begin
    ma = l1_q;
    mb = l2_q;
    case (step_q)
      2'd1: begin
        ma = WideBits'(a_i);
        mb = WideBits'(b_i);
      end
      2'd2: begin
        ma = WideBits'(c_i);
        mb = WideBits'(d_i);
      end
      default: begin
        ma = l1_q;
        mb = l2_q;
      end
    endcase
  end

  // one multiply, round to nearest with ties up via arithmetic shift
  assign prod  = ProdBits'(mb - ma) * $signed({1'b0, t_i}) + ProdBits'(32768);
  assign mixed = ma + WideBits'(prod >>> TBits);

  always_comb begin
    step_d = step_q;
    l1_d   = l1_q;
    l2_d   = l2_q;
    case (step_q)
      2'd0: if (start_i) step_d = 2'd1;
      2'd1: begin
        l1_d   = mixed;
        step_d = 2'd2;
      end
      2'd2: begin
        l2_d   = mixed;
        step_d = 2'd3;
      end
      default: begin
        step_d = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l1_q <= l1_d;
    l2_q <= l2_d;
  end

  assign done_o = (step_q == 2'd3);
  assign res_o  = mixed;

endmodule

// ----- hw/rtl/cfs_root_div.sv -----
// Bit-serial unit: integer square root (two bits per step) or
// restoring division (one bit per step), shared by the sequencer.
module cfs_root_div
  import cfs_pkg::*;
#(
  parameter int unsigned SumBits = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_sqrt_i,
  input  logic               start_div_i,
  input  logic [SumBits-1:0] radicand_i,
  input  logic [31:0]        dividend_i,
  input  logic [SumBits-1:0] divisor_i,
  output logic               busy_o,
  output logic [SumBits-1:0] result_o
);

  localparam int unsigned CntBits = $clog2(SumBits + 1);

  logic               busy_q, mode_q;
  logic [CntBits-1:0] cnt_q;
  logic [SumBits-1:0] rem_q, res_q, bit_q, dsor_q;
  logic [31:0]        quo_q;
  logic [SumBits:0]   trial_div;
  logic [SumBits:0]   shifted;

  assign shifted   = {rem_q, quo_q[31]};
  assign trial_div = shifted - {1'b0, dsor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_sqrt_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntBits'(SumBits / 2);
    end else if (start_div_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntBits'(32);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_sqrt_i) begin
      mode_q <= 1'b0;
      rem_q  <= radicand_i;
      res_q  <= '0;
      bit_q  <= SumBits'(1) << (SumBits - 2);
    end else if (start_div_i) begin
      mode_q <= 1'b1;
      rem_q  <= '0;
      quo_q  <= dividend_i;
      dsor_q <= divisor_i;
    end else if (busy_q) begin
      if (!mode_q) begin
        // one root digit per step
        if (rem_q >= res_q + bit_q) begin
          rem_q <= rem_q - (res_q + bit_q);
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end else begin
        // one quotient bit per step
        if (!trial_div[SumBits]) begin
          rem_q <= trial_div[SumBits-1:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= shifted[SumBits-1:0];
          quo_q <= {quo_q[30:0], 1'b0};
        end
      end
    end
  end

  assign busy_o   = busy_q;
  assign result_o = mode_q ? SumBits'(quo_q) : res_q;

endmodule

// ----- hw/rtl/curve_follower_step.sv -----
// Curve follower step.
// Configuration: write cfg_we_i with cfg_index_i (0..3 for point one..four)
// and cfg_wdata_i; write only while the block is idle. Other indexes ignored.
// Input channel: in_valid_i / in_stall_o carry step_distance_i. The block
// takes one word and then holds in_stall_o high until its result is taken.
// Output channel: out_valid_o / out_stall_i carry the new position, the new
// curve parameter and segment_done_o. The result is held while stalled.
// Sequence: six curve coordinate evaluations in the shared mix unit, the
// square root and the divide (32 serial steps each plus start and finish),
// then three more evaluations for the new position, with sequencing states
// between. A zero chord skips the divide. A new word is taken only after
// the result has been taken. The rate is set by the serial root and divider
// and the single mix multiplier.
// Reset clears the control points and the curve parameter to zero.
module curve_follower_step
  import cfs_pkg::*;
#(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxBits-1:0]       cfg_index_i,
  input  logic [RegBits-1:0]          cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [15:0]                 step_distance_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [CoordBits-1:0] pos_x_o,
  output logic signed [CoordBits-1:0] pos_y_o,
  output logic signed [CoordBits-1:0] pos_z_o,
  output logic [TBits-1:0]            curve_param_o,
  output logic                        segment_done_o
);

  localparam int unsigned WideBits = CoordBits + 20;
  localparam int unsigned SumBits  = 64;

  logic [RegBits-1:0] pts_q [NumRegs];
  logic [TBits-1:0]   t_q;
  logic [15:0]        dist_q;
  cfs_state_e         st_q, st_d;
  logic [1:0]         axis_q, smp_q;
  logic signed [WideBits-1:0] v1_q [3];
  logic signed [WideBits-1:0] v2_q [3];
  logic signed [CoordBits-1:0] pos_q [3];
  logic [SumBits-1:0] sum_q, len_q;
  logic               done_q;
  logic               mix_busy_q;

  // coordinate fetch, zero past the 48-bit register
  function automatic logic signed [CoordBits-1:0] coord(input logic [RegBits-1:0] r,
                                                        input logic [1:0] k);
    logic [3*CoordBits+RegBits-1:0] ext;
    ext   = {{(3*CoordBits){1'b0}}, r};
    coord = ext[k*CoordBits +: CoordBits];
  endfunction

  cfs_mix_cmd_t cmd;
  logic         mix_done;
  logic signed [WideBits-1:0] mix_res;
  logic [TBits:0] t_eval;

  assign t_eval = (smp_q == 2'd1) ? ({1'b0, t_q} + (TBits+1)'(TStep)) : {1'b0, t_q};
  assign cmd.start  = (st_q == ST_MIX || st_q == ST_POS) && !mix_busy_q;
  assign cmd.axis   = axis_q;
  assign cmd.sample = smp_q;

  cfs_mix #(.CoordBits(CoordBits), .WideBits(WideBits)) u_mix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd.start),
    .a_i    (coord(pts_q[0], cmd.axis)),
    .b_i    (coord(pts_q[1], cmd.axis)),
    .c_i    (coord(pts_q[2], cmd.axis)),
    .d_i    (coord(pts_q[3], cmd.axis)),
    .t_i    (t_eval),
    .done_o (mix_done),
    .res_o  (mix_res)
  );

  logic start_sqrt, start_div, rd_busy;
  logic [SumBits-1:0] rd_res;

  cfs_root_div #(.SumBits(SumBits)) u_rd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_sqrt_i(start_sqrt),
    .start_div_i (start_div),
    .radicand_i  (sum_q),
    .dividend_i  (32'(dist_q) * 32'(TStep)),
    .divisor_i   (len_q),
    .busy_o      (rd_busy),
    .result_o    (rd_res)
  );

  // difference magnitude of current axis
  logic signed [WideBits-1:0] dif;
  logic [WideBits-1:0]        mag;
  assign dif = v2_q[axis_q] - v1_q[axis_q];
  assign mag = dif[WideBits-1] ? WideBits'(-dif) : WideBits'(dif);

  logic [TBits+1:0] nt;
  assign nt = {2'b0, t_q} + (TBits+2)'(rd_res[31:0] > 32'h1ffff ? 32'h1ffff : rd_res[31:0]);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_valid_i) st_d = ST_MIX;
      ST_MIX:  if (mix_done && axis_q == 2'd2 && smp_q == 2'd1) st_d = ST_DIFF;
      ST_DIFF: if (axis_q == 2'd2) st_d = ST_SQRT;
      ST_SQRT: if (!rd_busy && !start_sqrt) st_d = ST_DIV;
      ST_DIV:  if (!rd_busy && !start_div) st_d = ST_UPD;
      ST_UPD:  st_d = ST_POS;
      ST_POS:  if (mix_done && axis_q == 2'd2) st_d = ST_OUT;
      ST_OUT:  if (!out_stall_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // unit starts
  logic sqrt_go_q, div_go_q;
  assign start_sqrt = (st_q == ST_SQRT) && sqrt_go_q;
  assign start_div  = (st_q == ST_DIV) && div_go_q && (len_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      for (int i = 0; i < NumRegs; i++) pts_q[i] <= '0;
      t_q        <= '0;
      axis_q     <= '0;
      smp_q      <= '0;
      mix_busy_q <= 1'b0;
      sqrt_go_q  <= 1'b0;
      div_go_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) pts_q[cfg_index_i] <= cfg_wdata_i;
      if (cmd.start) mix_busy_q <= 1'b1;
      if (mix_done) mix_busy_q <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          axis_q <= '0;
          smp_q  <= '0;
        end
        ST_MIX: if (mix_done) begin
          if (smp_q == 2'd1) begin
            smp_q  <= '0;
            axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
          end else begin
            smp_q <= 2'd1;
          end
        end
        ST_DIFF: begin
          axis_q    <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
          sqrt_go_q <= (axis_q == 2'd2);
        end
        ST_SQRT: begin
          sqrt_go_q <= 1'b0;
          div_go_q  <= 1'b1;
        end
        ST_DIV: div_go_q <= 1'b0;
        ST_UPD: begin
          if (len_q == '0 || nt[TBits+1:TBits] != 2'b00) begin
            t_q    <= '0;
            done_q <= 1'b1;
          end else begin
            t_q    <= nt[TBits-1:0];
            done_q <= 1'b0;
          end
          axis_q <= '0;
        end
        ST_POS: if (mix_done) axis_q <= axis_q + 2'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_valid_i) dist_q <= step_distance_i;
    if (st_q == ST_IDLE) sum_q <= '0;
    if (st_q == ST_MIX && mix_done) begin
      if (smp_q == 2'd1) v2_q[axis_q] <= mix_res;
      else v1_q[axis_q] <= mix_res;
    end
    if (st_q == ST_DIFF) sum_q <= sum_q + SumBits'(mag) * SumBits'(mag);
    if (st_q == ST_SQRT && !rd_busy && !start_sqrt) len_q <= rd_res;
    if (st_q == ST_POS && mix_done) pos_q[axis_q] <= mix_res[CoordBits-1:0];
  end

  assign in_stall_o     = (st_q != ST_IDLE);
  assign out_valid_o    = (st_q == ST_OUT);
  assign pos_x_o        = pos_q[0];
  assign pos_y_o        = pos_q[1];
  assign pos_z_o        = pos_q[2];
  assign curve_param_o  = t_q;
  assign segment_done_o = done_q;

  `include "curve_follower_step_assert.svh"

  `CFS_ASSERT_IMP(a_busy_stall, clk_i, rst_ni, out_valid_o, in_stall_o, "result while ready")
  `CFS_ASSERT_IMP(a_done_zero, clk_i, rst_ni, out_valid_o && segment_done_o, curve_param_o == '0, "done with t")
  `CFS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped")

endmodule
